/* rtl/tsvf_pkg.sv */
// Shared types, codes and constants of the state variable filter.
`default_nettype none
package tsvf_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int STATE_WIDTH_DEF    = 32;
    localparam int STATE_FRAC_BITS    = 8;
    localparam int CFG_INDEX_WIDTH    = 3;

    localparam int MODE_RESET    = 0;
    localparam int A1_RESET      = 59051;
    localparam int A2_RESET      = 3870;
    localparam int A3_RESET      = 254;
    localparam int DAMPING_RESET = 105513;

    typedef enum logic [1:0] {
        MODE_LOWPASS  = 2'd0,
        MODE_HIGHPASS = 2'd1,
        MODE_BANDPASS = 2'd2,
        MODE_NOTCH    = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MODE    = 3'd0,
        REG_A1      = 3'd1,
        REG_A2      = 3'd2,
        REG_A3      = 3'd3,
        REG_DAMPING = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_FIN
    } seq_state_t;

    typedef enum logic [1:0] {
        OPND_S1,
        OPND_V3,
        OPND_V1
    } opnd_sel_t;

    typedef enum logic [1:0] {
        COEF_A1,
        COEF_A2,
        COEF_A3,
        COEF_K
    } coef_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_HALF,
        ACC_SUM
    } acc_op_t;

    typedef struct packed {
        opnd_sel_t opnd_sel;
        coef_sel_t coef_sel;
        acc_op_t   acc_op;
        logic      ld_in;
        logic      ld_v1;
        logic      ld_v2;
        logic      ld_d;
        logic      ld_y;
        logic      ld_out;
    } ctrl_t;

endpackage
`default_nettype wire

/* rtl/tsvf_cfg.sv */
// Configuration register file: mode, coefficients and damping.
`default_nettype none
module tsvf_cfg #(
    parameter int COEF_W = tsvf_pkg::COEF_FRAC_BITS_DEF + 2
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 wr_en,
    input  wire logic [tsvf_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
    input  wire logic [COEF_W-1:0]                    wr_data,
    output tsvf_pkg::mode_t                           mode,
    output logic [COEF_W-1:0]                         a1,
    output logic [COEF_W-1:0]                         a2,
    output logic [COEF_W-1:0]                         a3,
    output logic [COEF_W-1:0]                         damping
);
    import tsvf_pkg::*;

    mode_t             mode_reg;
    logic [COEF_W-1:0] a1_reg;
    logic [COEF_W-1:0] a2_reg;
    logic [COEF_W-1:0] a3_reg;
    logic [COEF_W-1:0] damping_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= mode_t'(MODE_RESET);
            a1_reg      <= COEF_W'(A1_RESET);
            a2_reg      <= COEF_W'(A2_RESET);
            a3_reg      <= COEF_W'(A3_RESET);
            damping_reg <= COEF_W'(DAMPING_RESET);
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_MODE:    mode_reg    <= mode_t'(wr_data[1:0]);
                REG_A1:      a1_reg      <= wr_data;
                REG_A2:      a2_reg      <= wr_data;
                REG_A3:      a3_reg      <= wr_data;
                REG_DAMPING: damping_reg <= wr_data;
                default:     ;
            endcase
        end
    end

    assign mode    = mode_reg;
    assign a1      = a1_reg;
    assign a2      = a2_reg;
    assign a3      = a3_reg;
    assign damping = damping_reg;

endmodule
`default_nettype wire

/* rtl/tsvf_mul.sv */
// Shared registered multiplier: unsigned coefficient times signed operand.
`default_nettype none
module tsvf_mul #(
    parameter int COEF_W = tsvf_pkg::COEF_FRAC_BITS_DEF + 2,
    parameter int OPND_W = tsvf_pkg::STATE_WIDTH_DEF + 12
) (
    input  wire logic                            clk,
    input  wire logic        [COEF_W-1:0]        coef,
    input  wire logic signed [OPND_W-1:0]        opnd,
    output logic signed      [COEF_W+OPND_W:0]   prod
);
    logic signed [COEF_W+OPND_W:0] prod_reg;
    logic signed [COEF_W:0]        coef_s;

    assign coef_s = $signed({1'b0, coef});

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_s * opnd;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* rtl/tsvf_seq.sv */
// Sequencer that steps one sample through the shared multiplier.
`default_nettype none
module tsvf_seq (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      out_free,
    output logic           in_ready,
    output tsvf_pkg::ctrl_t ctrl
);
    import tsvf_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        ctrl          = '0;
        ctrl.opnd_sel = OPND_S1;
        ctrl.coef_sel = COEF_A1;
        ctrl.acc_op   = ACC_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.ld_in = 1'b1;
                    state_next = ST_M0;
                end
            end
            ST_M0:
            begin
                ctrl.opnd_sel = OPND_S1;
                ctrl.coef_sel = COEF_A1;
                state_next    = ST_M1;
            end
            ST_M1:
            begin
                ctrl.opnd_sel = OPND_V3;
                ctrl.coef_sel = COEF_A2;
                ctrl.acc_op   = ACC_HALF;
                state_next    = ST_M2;
            end
            ST_M2:
            begin
                ctrl.opnd_sel = OPND_S1;
                ctrl.coef_sel = COEF_A2;
                ctrl.ld_v1    = 1'b1;
                state_next    = ST_M3;
            end
            ST_M3:
            begin
                ctrl.opnd_sel = OPND_V3;
                ctrl.coef_sel = COEF_A3;
                ctrl.acc_op   = ACC_HALF;
                state_next    = ST_M4;
            end
            ST_M4:
            begin
                ctrl.opnd_sel = OPND_V1;
                ctrl.coef_sel = COEF_K;
                ctrl.acc_op   = ACC_SUM;
                state_next    = ST_M5;
            end
            ST_M5:
            begin
                ctrl.acc_op = ACC_HALF;
                ctrl.ld_v2  = 1'b1;
                state_next  = ST_M6;
            end
            ST_M6:
            begin
                ctrl.ld_d  = 1'b1;
                state_next = ST_M7;
            end
            ST_M7:
            begin
                ctrl.ld_y  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    ctrl.ld_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/tpt_state_variable_filter.sv */
// Top level of the trapezoidal state variable filter.
// One sample in, one filtered sample out. A new sample is not taken until the previous one
// has gone through all its steps in order: five products pass one by one through
// a single shared multiplier, followed by rounding, integrator update and output stages.
// The result sits in an output register, so a new sample is taken while it waits; the
// block holds in its last step only when the previous result is still untaken.
// tuser carries the clip flag, set when the output saturated to the sample range.
// Configuration writes are always ready and are meant for idle periods only.
`default_nettype none
module tpt_state_variable_filter #(
    parameter int SAMPLE_WIDTH   = tsvf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = tsvf_pkg::COEF_FRAC_BITS_DEF,
    parameter int STATE_WIDTH    = tsvf_pkg::STATE_WIDTH_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // sample_in
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // sample_out
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]             m_tdata,
    // clipped
    output logic [0:0]                                    m_tuser,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [tsvf_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [COEF_FRAC_BITS+1:0]                cfg_data
);
    import tsvf_pkg::*;

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int TD_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int XW     = SAMPLE_WIDTH + STATE_FRAC_BITS;
    localparam int MW     = (XW > STATE_WIDTH) ? XW : STATE_WIDTH;
    localparam int BW     = MW + 4;
    localparam int PW     = COEF_W + BW + 1;
    localparam int AW     = PW + 1;
    localparam int WIDE   = MW + 8;

    localparam logic signed [AW-1:0] RND_HALF =
        {{(AW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [WIDE-1:0] OUT_HALF =
        {{(WIDE-STATE_FRAC_BITS){1'b0}}, 1'b1, {(STATE_FRAC_BITS-1){1'b0}}};
    localparam logic signed [WIDE-1:0] ST_MAX =
        {{(WIDE-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [WIDE-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [WIDE-STATE_FRAC_BITS-1:0] SMP_MAX =
        {{(WIDE-STATE_FRAC_BITS-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [WIDE-STATE_FRAC_BITS-1:0] SMP_MIN = ~SMP_MAX;

    mode_t             mode;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] a3;
    logic [COEF_W-1:0] damping;
    ctrl_t             ctrl;
    logic              out_free;

    logic signed [STATE_WIDTH-1:0]  s1_reg;
    logic signed [STATE_WIDTH-1:0]  s2_reg;
    logic signed [WIDE-1:0]         x_reg;
    logic signed [BW-1:0]           v3_reg;
    logic signed [BW-1:0]           v1_reg;
    logic signed [WIDE-1:0]         v2_reg;
    logic signed [WIDE-1:0]         d_reg;
    logic signed [WIDE-1:0]         y_reg;
    logic signed [AW-1:0]           acc_reg;
    logic signed [AW-1:0]           acc_next;
    logic                           m_tvalid_reg;
    logic [SAMPLE_WIDTH-1:0]        sample_out_reg;
    logic                           clipped_reg;

    logic        [COEF_W-1:0]       mul_coef;
    logic signed [BW-1:0]           mul_opnd;
    logic signed [PW-1:0]           prod;
    logic signed [AW-1:0]           prod_ext;
    logic signed [AW-1:0]           acc_plus;
    logic signed [WIDE-1:0]         x_in;
    logic signed [WIDE-1:0]         v3_wide;
    logic signed [WIDE-1:0]         acc_shr;
    logic signed [WIDE-1:0]         v1_wide;
    logic signed [WIDE-1:0]         s1_wide;
    logic signed [WIDE-1:0]         s2_wide;
    logic signed [WIDE-1:0]         int1_raw;
    logic signed [WIDE-1:0]         int2_raw;
    logic signed [STATE_WIDTH-1:0]  int1_sat;
    logic signed [STATE_WIDTH-1:0]  int2_sat;
    logic signed [WIDE-1:0]         y_sel;
    logic signed [WIDE-STATE_FRAC_BITS-1:0] y_shr;
    logic        [SAMPLE_WIDTH-1:0] out_sat;
    logic                           out_clip;

    tsvf_cfg #(
        .COEF_W (COEF_W)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .mode     (mode),
        .a1       (a1),
        .a2       (a2),
        .a3       (a3),
        .damping  (damping)
    );

    tsvf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .in_ready (s_tready),
        .ctrl     (ctrl)
    );

    tsvf_mul #(
        .COEF_W (COEF_W),
        .OPND_W (BW)
    ) u_mul (
        .clk  (clk),
        .coef (mul_coef),
        .opnd (mul_opnd),
        .prod (prod)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        case (ctrl.coef_sel)
            COEF_A1: mul_coef = a1;
            COEF_A2: mul_coef = a2;
            COEF_A3: mul_coef = a3;
            COEF_K:  mul_coef = damping;
            default: mul_coef = a1;
        endcase
        case (ctrl.opnd_sel)
            OPND_S1: mul_opnd = BW'(s1_reg);
            OPND_V3: mul_opnd = v3_reg;
            OPND_V1: mul_opnd = v1_reg;
            default: mul_opnd = BW'(s1_reg);
        endcase
    end

    assign x_in     = WIDE'($signed(s_tdata[SAMPLE_WIDTH-1:0])) <<< STATE_FRAC_BITS;
    assign s1_wide  = WIDE'(s1_reg);
    assign s2_wide  = WIDE'(s2_reg);
    assign v3_wide  = x_in - s2_wide;
    assign prod_ext = AW'(prod);
    assign acc_plus = acc_reg + prod_ext;
    assign acc_shr  = acc_reg[AW-1:COEF_FRAC_BITS];
    assign v1_wide  = WIDE'(v1_reg);

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_HALF: acc_next = prod_ext + RND_HALF;
            ACC_SUM:  acc_next = acc_plus;
            default:  acc_next = acc_reg;
        endcase
    end

    assign int1_raw = (v1_wide <<< 1) - s1_wide;
    assign int2_raw = (v2_reg <<< 1) - s2_wide;

    always_comb
    begin
        if (int1_raw > ST_MAX)
        begin
            int1_sat = ST_MAX[STATE_WIDTH-1:0];
        end
        else if (int1_raw < ST_MIN)
        begin
            int1_sat = ST_MIN[STATE_WIDTH-1:0];
        end
        else
        begin
            int1_sat = int1_raw[STATE_WIDTH-1:0];
        end
        if (int2_raw > ST_MAX)
        begin
            int2_sat = ST_MAX[STATE_WIDTH-1:0];
        end
        else if (int2_raw < ST_MIN)
        begin
            int2_sat = ST_MIN[STATE_WIDTH-1:0];
        end
        else
        begin
            int2_sat = int2_raw[STATE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        case (mode)
            MODE_LOWPASS:  y_sel = v2_reg;
            MODE_HIGHPASS: y_sel = d_reg - v2_reg;
            MODE_BANDPASS: y_sel = v1_wide;
            MODE_NOTCH:    y_sel = d_reg;
            default:       y_sel = v2_reg;
        endcase
    end

    assign y_shr = y_reg[WIDE-1:STATE_FRAC_BITS];

    always_comb
    begin
        out_clip = 1'b0;
        if (y_shr > SMP_MAX)
        begin
            out_sat  = SMP_MAX[SAMPLE_WIDTH-1:0];
            out_clip = 1'b1;
        end
        else if (y_shr < SMP_MIN)
        begin
            out_sat  = SMP_MIN[SAMPLE_WIDTH-1:0];
            out_clip = 1'b1;
        end
        else
        begin
            out_sat = y_shr[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.ld_d)
            begin
                s1_reg <= int1_sat;
                s2_reg <= int2_sat;
            end
            if (ctrl.ld_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctrl.ld_in)
        begin
            x_reg  <= x_in;
            v3_reg <= v3_wide[BW-1:0];
        end
        if (ctrl.ld_v1)
        begin
            v1_reg <= acc_plus[COEF_FRAC_BITS+BW-1:COEF_FRAC_BITS];
        end
        if (ctrl.ld_v2)
        begin
            v2_reg <= s2_wide + acc_shr;
        end
        if (ctrl.ld_d)
        begin
            d_reg <= x_reg - acc_shr;
        end
        if (ctrl.ld_y)
        begin
            y_reg <= y_sel + OUT_HALF;
        end
        if (ctrl.ld_out)
        begin
            sample_out_reg <= out_sat;
            clipped_reg    <= out_clip;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TD_W'(sample_out_reg);
    assign m_tuser  = clipped_reg;

endmodule
`default_nettype wire
